// ===== hw/rtl/fkvm_pkg.sv =====
// Shared types and constants of the fixed-length key dictionary.
package fkvm_pkg;

   localparam int unsigned VALUE_W = 10;
   localparam int unsigned IN_VALUE_W = 16;
   localparam int unsigned STATUS_W = 3;
   localparam logic [IN_VALUE_W-1:0] VALUE_LIMIT = 16'd1000;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_REPLACED = 3'd1,
      ST_FULL     = 3'd2,
      ST_HIT      = 3'd3,
      ST_MISS     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic capture;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic issue_last;
      logic cmp_valid;
      logic cmp_match;
      logic cmp_last;
      logic out_free;
   } stat_type;

endpackage

// ===== hw/rtl/fkvm_ctrl.sv =====
// Controller state machine that sequences the scan, the update and the result.
module fkvm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fkvm_pkg::stat_type stat,
   output fkvm_pkg::cmd_type  cmd
);

   fkvm_pkg::state_type state_ff;
   fkvm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fkvm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         fkvm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.empty ? fkvm_pkg::S_FINISH : fkvm_pkg::S_SCAN;
            end
         end
         fkvm_pkg::S_SCAN: begin
            cmd.issue = 1'b1;
            cmd.capture = 1'b1;
            if (stat.cmp_valid && stat.cmp_match) begin
               state_in = fkvm_pkg::S_FINISH;
            end else if (stat.issue_last) begin
               state_in = fkvm_pkg::S_DRAIN;
            end
         end
         fkvm_pkg::S_DRAIN: begin
            cmd.capture = 1'b1;
            if (stat.cmp_valid && (stat.cmp_match || stat.cmp_last)) begin
               state_in = fkvm_pkg::S_FINISH;
            end
         end
         fkvm_pkg::S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in = fkvm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fkvm_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/fkvm_dp.sv =====
// Datapath with the key and value memories, scan pointer, fill count and result register.
module fkvm_dp #(
   parameter int unsigned ENTRIES = 64,
   parameter int unsigned KEY_BYTES = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fkvm_pkg::cmd_type                 cmd,
   output fkvm_pkg::stat_type                stat,
   input  logic                              req_mode,
   input  logic [8*KEY_BYTES-1:0]            req_key,
   input  logic [fkvm_pkg::IN_VALUE_W-1:0]   req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fkvm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fkvm_pkg::VALUE_W-1:0]      rsp_found_value
);

   localparam int unsigned KEY_W = 8 * KEY_BYTES;
   localparam int unsigned ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   logic [KEY_W-1:0]              key_mem [ENTRIES];
   logic [fkvm_pkg::VALUE_W-1:0]  val_mem [ENTRIES];

   logic                          mode_ff;
   logic [KEY_W-1:0]              key_ff;
   logic [fkvm_pkg::VALUE_W-1:0]  sat_ff;
   logic [ADDR_W-1:0]             rd_addr_ff;
   logic [ADDR_W-1:0]             cmp_addr_ff;
   logic                          cmp_valid_ff;
   logic [KEY_W-1:0]              key_rd_ff;
   logic [fkvm_pkg::VALUE_W-1:0]  val_rd_ff;
   logic                          hit_ff;
   logic [ADDR_W-1:0]             hit_addr_ff;
   logic [fkvm_pkg::VALUE_W-1:0]  hit_value_ff;
   logic [CNT_W-1:0]              fill_ff;
   logic                          rsp_valid_ff;
   fkvm_pkg::status_type          status_ff;
   logic [fkvm_pkg::VALUE_W-1:0]  found_ff;

   logic [CNT_W-1:0]              fill_in;
   logic                          rsp_valid_in;
   fkvm_pkg::status_type          status_in;
   logic [fkvm_pkg::VALUE_W-1:0]  found_in;
   logic [fkvm_pkg::VALUE_W-1:0]  sat_in;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic                          table_full;

   assign table_full = (fill_ff == FULL_COUNT);

   assign sat_in = (req_value > fkvm_pkg::VALUE_LIMIT) ?
                   fkvm_pkg::VALUE_W'(fkvm_pkg::VALUE_LIMIT) :
                   req_value[fkvm_pkg::VALUE_W-1:0];

   assign stat.empty = (fill_ff == '0);
   assign stat.issue_last = ((CNT_W'(rd_addr_ff) + CNT_W'(1)) == fill_ff);
   assign stat.cmp_valid = cmp_valid_ff;
   assign stat.cmp_match = (key_rd_ff == key_ff);
   assign stat.cmp_last = ((CNT_W'(cmp_addr_ff) + CNT_W'(1)) == fill_ff);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      fill_in = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in = status_ff;
      found_in = found_ff;
      wr_en = 1'b0;
      wr_addr = hit_addr_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         found_in = '0;
         if (!mode_ff) begin
            if (hit_ff) begin
               wr_en = 1'b1;
               status_in = fkvm_pkg::ST_REPLACED;
            end else if (!table_full) begin
               wr_en = 1'b1;
               wr_addr = fill_ff[ADDR_W-1:0];
               fill_in = fill_ff + CNT_W'(1);
               status_in = fkvm_pkg::ST_INSERTED;
            end else begin
               status_in = fkvm_pkg::ST_FULL;
            end
         end else if (hit_ff) begin
            status_in = fkvm_pkg::ST_HIT;
            found_in = hit_value_ff;
         end else begin
            status_in = fkvm_pkg::ST_MISS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= key_ff;
         val_mem[wr_addr] <= sat_ff;
      end
      key_rd_ff <= key_mem[rd_addr_ff];
      val_rd_ff <= val_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
         hit_ff <= 1'b0;
         rd_addr_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_valid_ff <= cmd.issue;
         if (cmd.load) begin
            hit_ff <= 1'b0;
            rd_addr_ff <= '0;
         end else begin
            if (cmd.capture && cmp_valid_ff && stat.cmp_match) begin
               hit_ff <= 1'b1;
            end
            if (cmd.issue) begin
               rd_addr_ff <= rd_addr_ff + ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      found_ff <= found_in;
      cmp_addr_ff <= rd_addr_ff;
      if (cmd.load) begin
         mode_ff <= req_mode;
         key_ff <= req_key;
         sat_ff <= sat_in;
      end
      if (cmd.capture && cmp_valid_ff && stat.cmp_match) begin
         hit_addr_ff <= cmp_addr_ff;
         hit_value_ff <= val_rd_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found_value = found_ff;

endmodule

// ===== hw/rtl/fixed_key_value_map.sv =====
// Top level of the fixed-length key dictionary with insert and lookup words.
// One word is worked at a time; the key memory is read one entry per cycle.
// The result word is registered once the scan of the filled entries ends and the output is free;
// an empty table skips the scan, an early hit ends it, and a full table scans all ENTRIES entries.
// A new word is accepted only after the previous result is issued, back in the idle state.
// Synchronous reset clears the fill count and control; memory contents are not cleared.
module fixed_key_value_map #(
   parameter int unsigned ENTRIES = 64,
   parameter int unsigned KEY_BYTES = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [8*KEY_BYTES-1:0]            req_key,
   input  logic [fkvm_pkg::IN_VALUE_W-1:0]   req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fkvm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fkvm_pkg::VALUE_W-1:0]      rsp_found_value
);

   fkvm_pkg::cmd_type  cmd;
   fkvm_pkg::stat_type stat;

   fkvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fkvm_dp #(
      .ENTRIES   (ENTRIES),
      .KEY_BYTES (KEY_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

endmodule

// ===== bench/fixed_key_value_map_checker.sv =====
// Checker that predicts and compares the result words of the fixed-length key dictionary.
`timescale 1ns / 100ps

module fixed_key_value_map_checker #(
   parameter int unsigned ENTRIES = 64,
   parameter int unsigned KEY_BYTES = 3,
   parameter bit LOOKUP_MODE = 1'b1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_mode,
   input  logic [8*KEY_BYTES-1:0]            req_key,
   input  logic [fkvm_pkg::IN_VALUE_W-1:0]   req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [fkvm_pkg::STATUS_W-1:0]     rsp_status,
   input  logic [fkvm_pkg::VALUE_W-1:0]      rsp_found_value,
   output int                                mismatches,
   output int                                pending
);

   localparam int unsigned KEY_W = 8 * KEY_BYTES;

   typedef struct {
      fkvm_pkg::status_type         status;
      logic [fkvm_pkg::VALUE_W-1:0] found_value;
   } answer_type;

   logic [KEY_W-1:0]             slot_key [ENTRIES];
   logic [fkvm_pkg::VALUE_W-1:0] slot_value [ENTRIES];
   int                           stored = 0;
   answer_type                   answer_q [$];
   int                           mismatch_total = 0;

   function automatic answer_type dictionary_apply(input logic op, input logic [KEY_W-1:0] k,
                                                   input logic [fkvm_pkg::IN_VALUE_W-1:0] v);
      answer_type                   a;
      int                           hit;
      logic [fkvm_pkg::VALUE_W-1:0] sat;
      sat = (v > fkvm_pkg::VALUE_LIMIT) ? fkvm_pkg::VALUE_W'(fkvm_pkg::VALUE_LIMIT)
                                        : v[fkvm_pkg::VALUE_W-1:0];
      hit = -1;
      for (int i = 0; i < stored; i++) begin
         if (hit < 0 && slot_key[i] == k) begin
            hit = i;
         end
      end
      a.found_value = '0;
      if (op != LOOKUP_MODE) begin
         if (hit >= 0) begin
            slot_value[hit] = sat;
            a.status = fkvm_pkg::ST_REPLACED;
         end else if (stored < ENTRIES) begin
            slot_key[stored] = k;
            slot_value[stored] = sat;
            stored++;
            a.status = fkvm_pkg::ST_INSERTED;
         end else begin
            a.status = fkvm_pkg::ST_FULL;
         end
      end else if (hit >= 0) begin
         a.status = fkvm_pkg::ST_HIT;
         a.found_value = slot_value[hit];
      end else begin
         a.status = fkvm_pkg::ST_MISS;
      end
      return a;
   endfunction

   always @(posedge clock) begin : watch
      answer_type exp_answer;
      if (reset) begin
         stored = 0;
         answer_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10) begin
                  $display("%0t: unexpected result word, status %0d found_value %0d",
                           $time, rsp_status, rsp_found_value);
               end
            end else begin
               exp_answer = answer_q.pop_front();
               if (rsp_status !== exp_answer.status ||
                   rsp_found_value !== exp_answer.found_value) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("%0t: expected status %0d value %0d, got %0d value %0d",
                              $time, exp_answer.status, exp_answer.found_value,
                              rsp_status, rsp_found_value);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            answer_q.push_back(dictionary_apply(req_mode, req_key, req_value));
         end
      end
      mismatches <= mismatch_total;
      pending <= answer_q.size();
   end

endmodule

// ===== bench/fixed_key_value_map_tb.sv =====
// Testbench top that drives insert and lookup words into the fixed-length key dictionary.
`timescale 1ns / 100ps

module fixed_key_value_map_tb;

   localparam int unsigned ENTRIES = 64;
   localparam int unsigned KEY_BYTES = 3;
   localparam int unsigned KEY_W = 8 * KEY_BYTES;
   localparam bit MODE_INSERT = 1'b0;
   localparam bit MODE_LOOKUP = 1'b1;
   localparam int POOL_SIZE = 72;
   localparam int RANDOM_WORDS = 2000;
   localparam int DRAIN_AT = 1200;
   localparam int HOLD_AT = 25000;
   localparam int HOLD_CYCLES = 800;
   localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_mode = MODE_INSERT;
   logic [KEY_W-1:0]                    req_key = '0;
   logic [fkvm_pkg::IN_VALUE_W-1:0]     req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [fkvm_pkg::STATUS_W-1:0]       rsp_status;
   logic [fkvm_pkg::VALUE_W-1:0]        rsp_found_value;
   int                                  mismatches;
   int                                  pending;
   logic [KEY_W-1:0]                    key_pool [POOL_SIZE];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fixed_key_value_map #(
      .ENTRIES(ENTRIES),
      .KEY_BYTES(KEY_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_key(req_key),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value)
   );

   fixed_key_value_map_checker #(
      .ENTRIES(ENTRIES),
      .KEY_BYTES(KEY_BYTES),
      .LOOKUP_MODE(MODE_LOOKUP)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_key(req_key),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value),
      .mismatches(mismatches),
      .pending(pending)
   );

   task automatic offer_word(input logic op, input logic [KEY_W-1:0] k,
                             input logic [fkvm_pkg::IN_VALUE_W-1:0] v);
      req_valid <= 1'b1;
      req_mode <= op;
      req_key <= k;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [fkvm_pkg::IN_VALUE_W-1:0] random_amount();
      case ($urandom_range(0, 5))
         0: return fkvm_pkg::IN_VALUE_W'($urandom_range(0, 1000));
         1: return fkvm_pkg::IN_VALUE_W'($urandom_range(990, 1010));
         2: return fkvm_pkg::IN_VALUE_W'($urandom_range(0, 16'hFFFF));
         3: return '0;
         4: return '1;
         default: return fkvm_pkg::VALUE_LIMIT;
      endcase
   endfunction

   task automatic random_traffic(input int count);
      int               burst_left;
      int               choice;
      int               gap;
      logic             op;
      logic [KEY_W-1:0] k;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
         end
         op = ($urandom_range(0, 1) == 1) ? MODE_LOOKUP : MODE_INSERT;
         choice = $urandom_range(0, 99);
         k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (choice >= 90) begin
            k = KEY_W'($urandom_range(0, 2**KEY_W - 1));
         end else if (choice >= 80) begin
            k = k ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
         end
         offer_word(op, k, random_amount());
         burst_left--;
         if (n == DRAIN_AT) begin
            req_valid <= 1'b0;
            wait_for_drain();
         end else if (burst_left == 0) begin
            gap = $urandom_range(0, 16);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   initial begin : receiver
      int rx_cycle;
      int run_left;
      int stall_style;
      rx_cycle = 0;
      run_left = 0;
      stall_style = 0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               stall_style = $urandom_range(0, 2);
               run_left = $urandom_range(16, 160);
            end
            run_left--;
            case (stall_style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      for (int p = 0; p < POOL_SIZE; p++) begin
         key_pool[p] = KEY_W'($urandom_range(0, 2**KEY_W - 1));
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Miss on an empty table, then the key extremes and value saturation.
      offer_word(MODE_LOOKUP, 24'h000000, 16'h0000);
      offer_word(MODE_INSERT, 24'h000000, 16'h0000);
      offer_word(MODE_LOOKUP, 24'h000000, 16'hFFFF);
      offer_word(MODE_INSERT, 24'hFFFFFF, 16'hFFFF);
      offer_word(MODE_LOOKUP, 24'hFFFFFF, 16'h0000);
      offer_word(MODE_INSERT, 24'h000000, 16'd1001);
      offer_word(MODE_LOOKUP, 24'h000000, 16'h1234);
      offer_word(MODE_INSERT, 24'h000001, 16'd999);
      offer_word(MODE_LOOKUP, 24'h010000, 16'h0000);
      offer_word(MODE_LOOKUP, 24'h000001, 16'h0000);
      offer_word(MODE_INSERT, 24'hFFFFFE, 16'd1000);
      offer_word(MODE_LOOKUP, 24'h7FFFFF, 16'h0000);
      offer_word(MODE_LOOKUP, 24'hFFFFFF, 16'hFFFF);
      offer_word(MODE_INSERT, 24'hAAAAAA, 16'h5555);
      offer_word(MODE_INSERT, 24'h555555, 16'h02AA);
      offer_word(MODE_LOOKUP, 24'h555555, 16'hAAAA);
      offer_word(MODE_LOOKUP, 24'hAAAAAA, 16'h0000);
      offer_word(MODE_INSERT, 24'hFFFFFF, 16'd1);
      offer_word(MODE_LOOKUP, 24'hFFFFFF, 16'h0000);
      offer_word(MODE_LOOKUP, 24'hFFFFFE, 16'h0000);

      random_traffic(RANDOM_WORDS);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
